// ----- src/packed10_pixel_unpack_crop_top_assert.svh -----
// Assertion macros shared by the packed ten-bit unpacker RTL.
// No dependencies; the modules that check their own logic include this file.
`ifndef PACKED10_PIXEL_UNPACK_CROP_TOP_ASSERT_SVH
`define PACKED10_PIXEL_UNPACK_CROP_TOP_ASSERT_SVH

// Condition must hold at every clock edge outside reset.
`define PUP_ASSERT_ALWAYS(label, clk, rst_n, cond) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (cond)) \
        else $error("pup assertion failed");

// Consequent must hold in the same cycle as the antecedent.
`define PUP_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("pup assertion failed");

// Consequent must hold in the cycle after the antecedent.
`define PUP_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("pup assertion failed");

`endif

// ----- src/pup_pkg.sv -----
// Shared types, constants and the intensity mapping for the packed ten-bit unpacker.
// No dependencies; the RTL files refer to it by scoped names and the testbench imports it.
`timescale 1ns / 1ps

package pup_pkg;

    // Default geometry limits
    localparam int unsigned MAX_WIDTH_DEF  = 4096;
    localparam int unsigned MAX_HEIGHT_DEF = 4096;

    // Field widths
    localparam int unsigned BYTE_W     = 8;
    localparam int unsigned RAW_W      = 10;
    localparam int unsigned PIXEL_W    = 8;
    localparam int unsigned CFG_DATA_W = 13;
    localparam int unsigned CFG_IDX_W  = 3;
    localparam int unsigned SIZE_W     = 13;
    localparam int unsigned BEGIN_W    = 12;
    localparam int unsigned PHASE_W    = 3;
    localparam int unsigned M_TDATA_W  = 24;

    // Group layout: five bytes carry four pixels
    localparam logic [PHASE_W-1:0] PHASE_LAST = 3'd4;

    // Queue between front and back
    localparam int unsigned QUEUE_DEPTH = 4;

    // Knees of the intensity curve
    localparam logic [RAW_W-1:0] LUT_KNEE_LO = 10'd342;
    localparam logic [RAW_W-1:0] LUT_KNEE_HI = 10'd683;

    // Configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_IMAGE_WIDTH = 3'd0,
        CFG_WIN_X_BEGIN = 3'd1,
        CFG_WIN_WIDTH   = 3'd2,
        CFG_WIN_Y_BEGIN = 3'd3,
        CFG_WIN_HEIGHT  = 3'd4
    } cfg_index_t;

    // Configuration register file
    typedef struct packed {
        logic [SIZE_W-1:0]  image_width;
        logic [BEGIN_W-1:0] win_x_begin;
        logic [SIZE_W-1:0]  win_width;
        logic [BEGIN_W-1:0] win_y_begin;
        logic [SIZE_W-1:0]  win_height;
    } pup_cfg_t;

    // One windowed pixel on its way to the back end
    typedef struct packed {
        logic [RAW_W-1:0] raw_value;
        logic             window_last;
    } pup_item_t;

    // One result as presented on the master side
    typedef struct packed {
        logic [PIXEL_W-1:0] pixel;
        logic [RAW_W-1:0]   raw_value;
        logic               window_last;
    } pup_result_t;

    // Ten-bit raw to eight-bit intensity: three linear pieces
    function automatic logic [PIXEL_W-1:0] intensity_lut(input logic [RAW_W-1:0] raw);
        logic [RAW_W:0] t;
        if (raw <= LUT_KNEE_LO) begin
            t = {1'b0, raw} + 11'd1;
        end else if (raw <= LUT_KNEE_HI) begin
            t = {1'b0, raw};
        end else begin
            t = {1'b0, raw} - 11'd1;
        end
        return t[RAW_W-1:2];
    endfunction

endpackage

// ----- src/packed10_pixel_unpack_crop_top.sv -----
// Top level of the packed ten-bit pixel unpacker with crop window.
// Depends on pup_pkg, pup_front, pup_queue and pup_back.
`timescale 1ns / 1ps

// Usage:
//   s_ channel: one packed byte per beat, s_tuser high on the first byte of a
//   frame. Every five bytes carry four ten-bit pixels, MSB first; each byte after
//   the first of a group completes one pixel.
//   m_ channel: one beat per pixel inside the crop window, carrying the 8-bit
//   intensity, the raw value, and m_tlast on the window's last pixel.
//   cfg_ channel: register writes (index, data), always ready; write only while
//   the stream is idle.
// Path: a pixel is written into the queue at the edge that accepts its byte,
// then moves into the output register once that register is empty or being
// taken, which raises m_tvalid.
// Throughput: one byte per cycle while s_tready is high, set by the combinational
// unpack and window test in the front end; the back end drains one result per cycle while m_tready is high.
// Stall: while m_tready is low the four-entry queue fills, then s_tready drops
// until the back end frees an entry.
// Reset: counters, group phase and byte history clear, registers take
// width 1024, window at origin 1024 by 1024; queue and output empty.
module packed10_pixel_unpack_crop_top #(
    parameter int unsigned MAX_WIDTH  = pup_pkg::MAX_WIDTH_DEF,
    parameter int unsigned MAX_HEIGHT = pup_pkg::MAX_HEIGHT_DEF
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [pup_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [pup_pkg::CFG_DATA_W-1:0]  cfg_data,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [pup_pkg::BYTE_W-1:0]      s_tdata,   // [7:0] packed_byte
    input  logic                            s_tuser,   // [0] frame_start
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [pup_pkg::M_TDATA_W-1:0]   m_tdata,   // [7:0] pixel, [17:8] raw_value
    output logic                            m_tlast    // window_last
);

    logic               q_full, q_push, q_empty, q_pop;
    pup_pkg::pup_item_t q_in, q_head;

    pup_front #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .q_full    (q_full),
        .q_push    (q_push),
        .q_item    (q_in)
    );

    pup_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (q_push),
        .push_item (q_in),
        .full      (q_full),
        .pop       (q_pop),
        .empty     (q_empty),
        .head_item (q_head)
    );

    pup_back u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .q_empty  (q_empty),
        .q_head   (q_head),
        .q_pop    (q_pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

endmodule

// ----- src/pup_front.sv -----
// Front end: config registers, byte unpacking, raster counters and window test.
// Depends on pup_pkg and the assertion macro header.
`timescale 1ns / 1ps
`include "packed10_pixel_unpack_crop_top_assert.svh"

module pup_front #(
    parameter int unsigned MAX_WIDTH  = pup_pkg::MAX_WIDTH_DEF,
    parameter int unsigned MAX_HEIGHT = pup_pkg::MAX_HEIGHT_DEF
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    // configuration write channel
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [pup_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [pup_pkg::CFG_DATA_W-1:0]    cfg_data,
    // byte stream in
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [pup_pkg::BYTE_W-1:0]        s_tdata,
    input  logic                              s_tuser,
    // queue write side
    input  logic                              q_full,
    output logic                              q_push,
    output pup_pkg::pup_item_t                q_item
);

    localparam int unsigned CW   = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
    localparam int unsigned RW   = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
    localparam int unsigned MW0  = (CW > RW) ? CW : RW;
    localparam int unsigned MW1  = (MW0 > pup_pkg::SIZE_W) ? MW0 : pup_pkg::SIZE_W;
    localparam int unsigned CMPW = MW1 + 2;
    localparam logic [CMPW-1:0] MAXW_C = CMPW'(MAX_WIDTH);
    localparam logic [CMPW-1:0] MAXH_C = CMPW'(MAX_HEIGHT);
    localparam logic [CMPW-1:0] ONE_C  = CMPW'(1);

    pup_pkg::pup_cfg_t             cfg_reg, cfg_next;
    logic [pup_pkg::BYTE_W-1:0]    prev_reg, prev_next;
    logic [pup_pkg::PHASE_W-1:0]   phase_reg, phase_next;
    logic [CW-1:0]                 col_reg, col_next;
    logic [RW-1:0]                 row_reg, row_next;

    logic                          accept;
    logic [pup_pkg::PHASE_W-1:0]   phase_eff;
    logic [CW-1:0]                 col_eff;
    logic [RW-1:0]                 row_eff;
    logic [2*pup_pkg::BYTE_W-1:0]  pair;
    logic [pup_pkg::RAW_W-1:0]     raw;
    logic                          have;
    logic [CMPW-1:0]               col_w, row_w, xb_w, yb_w, ww_w, wh_w, iw_w, width_eff;
    logic [CMPW-1:0]               dx, dy;
    logic                          in_win, last;

    assign cfg_ready = 1'b1;
    assign s_tready  = !q_full;
    assign accept    = s_tvalid && s_tready;

    // Write config registers; unknown indexes are dropped
    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_valid) begin
            unique case (cfg_index)
                pup_pkg::CFG_IMAGE_WIDTH: cfg_next.image_width = cfg_data;
                pup_pkg::CFG_WIN_X_BEGIN: cfg_next.win_x_begin = cfg_data[pup_pkg::BEGIN_W-1:0];
                pup_pkg::CFG_WIN_WIDTH:   cfg_next.win_width   = cfg_data;
                pup_pkg::CFG_WIN_Y_BEGIN: cfg_next.win_y_begin = cfg_data[pup_pkg::BEGIN_W-1:0];
                pup_pkg::CFG_WIN_HEIGHT:  cfg_next.win_height  = cfg_data;
                default: ;
            endcase
        end
    end

    // Frame start clears phase and counters ahead of this beat
    assign phase_eff = s_tuser ? '0 : phase_reg;
    assign col_eff   = s_tuser ? '0 : col_reg;
    assign row_eff   = s_tuser ? '0 : row_reg;

    // Extract the pixel completed by this byte, MSB first
    assign pair = {prev_reg, s_tdata};
    always_comb begin
        have = 1'b1;
        unique case (phase_eff)
            3'd1:    raw = pair[15:6];
            3'd2:    raw = pair[13:4];
            3'd3:    raw = pair[11:2];
            3'd4:    raw = pair[9:0];
            default: begin
                raw  = '0;
                have = 1'b0;
            end
        endcase
    end

    // Window test on widened operands
    assign col_w = CMPW'(col_eff);
    assign row_w = CMPW'(row_eff);
    assign xb_w  = CMPW'(cfg_reg.win_x_begin);
    assign yb_w  = CMPW'(cfg_reg.win_y_begin);
    assign ww_w  = CMPW'(cfg_reg.win_width);
    assign wh_w  = CMPW'(cfg_reg.win_height);
    assign iw_w  = CMPW'(cfg_reg.image_width);
    assign dx    = col_w - xb_w;
    assign dy    = row_w - yb_w;
    assign in_win = (col_w >= xb_w) && (dx < ww_w) && (row_w >= yb_w) && (dy < wh_w);
    assign last   = in_win && (dx + ONE_C == ww_w) && (dy + ONE_C == wh_w);

    // Zero or oversized width falls back to the maximum
    assign width_eff = ((iw_w == '0) || (iw_w > MAXW_C)) ? MAXW_C : iw_w;

    // Advance phase, byte history and raster counters
    always_comb begin
        prev_next  = prev_reg;
        phase_next = phase_reg;
        col_next   = col_reg;
        row_next   = row_reg;
        if (accept) begin
            prev_next  = s_tdata;
            phase_next = (phase_eff >= pup_pkg::PHASE_LAST) ? '0 : phase_eff + 3'd1;
            col_next   = col_eff;
            row_next   = row_eff;
            if (have) begin
                if (col_w + ONE_C >= width_eff) begin
                    col_next = '0;
                    row_next = (row_w + ONE_C >= MAXH_C) ? '0 : RW'(row_w + ONE_C);
                end else begin
                    col_next = CW'(col_w + ONE_C);
                end
            end
        end
    end

    assign q_push             = accept && have && in_win;
    assign q_item.raw_value   = raw;
    assign q_item.window_last = last;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.image_width <= pup_pkg::SIZE_W'(1024);
            cfg_reg.win_x_begin <= '0;
            cfg_reg.win_width   <= pup_pkg::SIZE_W'(1024);
            cfg_reg.win_y_begin <= '0;
            cfg_reg.win_height  <= pup_pkg::SIZE_W'(1024);
            prev_reg            <= '0;
            phase_reg           <= '0;
            col_reg             <= '0;
            row_reg             <= '0;
        end else begin
            cfg_reg   <= cfg_next;
            prev_reg  <= prev_next;
            phase_reg <= phase_next;
            col_reg   <= col_next;
            row_reg   <= row_next;
        end
    end

    `PUP_ASSERT_ALWAYS(a_phase_range, aclk, aresetn, phase_reg <= pup_pkg::PHASE_LAST)
    `PUP_ASSERT_NEXT(a_frame_start_clear, aclk, aresetn, accept && s_tuser,
        phase_reg == 3'd1 && col_reg == '0 && row_reg == '0)
    `PUP_ASSERT_IMPLY(a_push_needs_room, aclk, aresetn, q_push, !q_full && phase_eff != '0)

endmodule

// ----- src/pup_queue.sv -----
// Short flip-flop queue that decouples the unpacking front from the output back end.
// Depends on pup_pkg and the assertion macro header.
`timescale 1ns / 1ps
`include "packed10_pixel_unpack_crop_top_assert.svh"

module pup_queue (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               push,
    input  pup_pkg::pup_item_t push_item,
    output logic               full,
    input  logic               pop,
    output logic               empty,
    output pup_pkg::pup_item_t head_item
);

    localparam int unsigned DEPTH = pup_pkg::QUEUE_DEPTH;
    localparam int unsigned PW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned NW    = $clog2(DEPTH + 1);
    localparam logic [PW-1:0] PTR_LAST = PW'(DEPTH - 1);
    localparam logic [NW-1:0] COUNT_FULL = NW'(DEPTH);

    pup_pkg::pup_item_t store_reg [DEPTH];
    logic [PW-1:0] wr_reg, wr_next, rd_reg, rd_next;
    logic [NW-1:0] count_reg, count_next;

    assign full      = (count_reg == COUNT_FULL);
    assign empty     = (count_reg == '0);
    assign head_item = store_reg[rd_reg];

    // Advance pointers and occupancy
    always_comb begin
        wr_next    = wr_reg;
        rd_next    = rd_reg;
        count_next = count_reg;
        if (push) begin
            wr_next = (wr_reg == PTR_LAST) ? '0 : wr_reg + PW'(1);
        end
        if (pop) begin
            rd_next = (rd_reg == PTR_LAST) ? '0 : rd_reg + PW'(1);
        end
        if (push && !pop) begin
            count_next = count_reg + NW'(1);
        end else if (pop && !push) begin
            count_next = count_reg - NW'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_reg    <= '0;
            rd_reg    <= '0;
            count_reg <= '0;
        end else begin
            wr_reg    <= wr_next;
            rd_reg    <= rd_next;
            count_reg <= count_next;
        end
    end

    // Hold payload; no reset needed
    always_ff @(posedge aclk) begin
        if (push) begin
            store_reg[wr_reg] <= push_item;
        end
    end

    `PUP_ASSERT_ALWAYS(a_count_bound, aclk, aresetn, count_reg <= COUNT_FULL)
    `PUP_ASSERT_IMPLY(a_pop_nonempty, aclk, aresetn, pop, count_reg != '0)
    `PUP_ASSERT_NEXT(a_push_grows, aclk, aresetn, push && !pop,
        count_reg == $past(count_reg) + NW'(1))

endmodule

// ----- src/pup_back.sv -----
// Back end: intensity mapping of queued pixels and the master-side output register.
// Depends on pup_pkg.
`timescale 1ns / 1ps

module pup_back (
    input  logic                           aclk,
    input  logic                           aresetn,
    // queue read side
    input  logic                           q_empty,
    input  pup_pkg::pup_item_t             q_head,
    output logic                           q_pop,
    // result stream out
    output logic                           m_tvalid,
    input  logic                           m_tready,
    output logic [pup_pkg::M_TDATA_W-1:0]  m_tdata,
    output logic                           m_tlast
);

    logic                  valid_reg, valid_next;
    pup_pkg::pup_result_t  out_reg, out_next;
    logic                  load;

    // Refill the output register when it is empty or being taken
    assign load  = !q_empty && (!valid_reg || m_tready);
    assign q_pop = load;

    always_comb begin
        out_next.pixel       = pup_pkg::intensity_lut(q_head.raw_value);
        out_next.raw_value   = q_head.raw_value;
        out_next.window_last = q_head.window_last;
    end

    always_comb begin
        valid_next = valid_reg;
        if (load) begin
            valid_next = 1'b1;
        end else if (m_tready) begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    // Hold payload while stalled
    always_ff @(posedge aclk) begin
        if (load) begin
            out_reg <= out_next;
        end
    end

    assign m_tvalid = valid_reg;
    assign m_tdata  = {{(pup_pkg::M_TDATA_W - pup_pkg::PIXEL_W - pup_pkg::RAW_W){1'b0}},
                       out_reg.raw_value, out_reg.pixel};
    assign m_tlast  = out_reg.window_last;

endmodule

// ----- sim/tb_top.sv -----
// Self-checking testbench for packed10_pixel_unpack_crop_top: byte stream in, windowed pixels out.
// Depends on pup_pkg (field widths, register indexes, result struct) and the RTL top level.
`timescale 1ns / 1ps

module tb_top;

    import pup_pkg::*;

    // Register writes the block must ignore
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_LO = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_HI = 3'd7;
    localparam int unsigned RANDOM_BYTES = 850;
    localparam int unsigned MAX_ERR_PRINTS = 20;

    typedef struct packed {
        logic [BYTE_W-1:0] data;
        logic              start;
    } byte_beat_t;

    logic                  aclk = 1'b0;
    logic                  aresetn = 1'b0;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [BYTE_W-1:0]     s_tdata = '0;   // [7:0] packed_byte
    logic                  s_tuser = 1'b0; // [0] frame_start
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [M_TDATA_W-1:0]  m_tdata;        // [7:0] pixel, [17:8] raw_value
    logic                  m_tlast;        // window_last

    // Bytes waiting for the sender, and pixels waiting for the output
    byte_beat_t  byte_q[$];
    pup_result_t window_pixels_q[$];
    int unsigned err_count = 0;

    // Shadow of the block: registers and unpack state
    logic [SIZE_W-1:0]  sh_image_width = 13'd1024;
    logic [BEGIN_W-1:0] sh_x_begin     = 12'd0;
    logic [SIZE_W-1:0]  sh_win_width   = 13'd1024;
    logic [BEGIN_W-1:0] sh_y_begin     = 12'd0;
    logic [SIZE_W-1:0]  sh_win_height  = 13'd1024;
    logic [BYTE_W-1:0]  sh_prev_byte   = '0;
    logic [PHASE_W-1:0] sh_phase       = '0;
    int unsigned        sh_column      = 0;
    int unsigned        sh_row         = 0;

    // Sender and receiver pacing
    logic        in_taken = 1'b0;
    int unsigned burst_left = 0;
    int unsigned gap_left = 0;
    int unsigned rx_cycle = 0;
    int unsigned hold_left = 0;
    int unsigned hold_asks = 0;
    int unsigned hold_done = 0;
    int unsigned seg_left = 0;
    int unsigned seg_mode = 0;

    packed10_pixel_unpack_crop_top dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // Intensity curve: three linear pieces split at the two knees
    function automatic logic [PIXEL_W-1:0] intensity_of(input logic [RAW_W-1:0] raw);
        int unsigned r;
        r = raw;
        if (r <= LUT_KNEE_LO) return PIXEL_W'((r + 1) >> 2);
        if (r <= LUT_KNEE_HI) return PIXEL_W'(r >> 2);
        return PIXEL_W'((r - 1) >> 2);
    endfunction

    function automatic void apply_reg(input logic [CFG_IDX_W-1:0] idx,
                                      input logic [CFG_DATA_W-1:0] val);
        case (idx)
            CFG_IMAGE_WIDTH: sh_image_width = val;
            CFG_WIN_X_BEGIN: sh_x_begin     = val[BEGIN_W-1:0];
            CFG_WIN_WIDTH:   sh_win_width   = val;
            CFG_WIN_Y_BEGIN: sh_y_begin     = val[BEGIN_W-1:0];
            CFG_WIN_HEIGHT:  sh_win_height  = val;
            default: ;
        endcase
    endfunction

    // Advance the shadow by one byte; queue the pixel it completes if it is windowed
    function automatic void unpack_byte(input logic [BYTE_W-1:0] cur, input logic fs);
        logic [15:0]      pair;
        logic [RAW_W-1:0] raw;
        logic             have;
        logic             in_win;
        logic             last;
        int unsigned      xb, ww, yb, wh, w;
        pup_result_t      res;
        have = 1'b0;
        raw = '0;
        if (fs) begin
            sh_phase = '0;
            sh_column = 0;
            sh_row = 0;
        end
        if (sh_phase != 0 && sh_phase <= PHASE_LAST) begin
            pair = {sh_prev_byte, cur};
            raw = RAW_W'(pair >> (8 - 2 * sh_phase));
            have = 1'b1;
        end
        sh_prev_byte = cur;
        sh_phase = (sh_phase >= PHASE_LAST) ? '0 : sh_phase + 1'b1;
        if (have) begin
            xb = sh_x_begin;
            ww = sh_win_width;
            yb = sh_y_begin;
            wh = sh_win_height;
            in_win = sh_column >= xb && sh_column - xb < ww &&
                     sh_row >= yb && sh_row - yb < wh;
            last = in_win && sh_column - xb + 1 == ww && sh_row - yb + 1 == wh;
            // zero or oversized width counts as the maximum
            w = sh_image_width;
            if (w == 0 || w > MAX_WIDTH_DEF) w = MAX_WIDTH_DEF;
            if (sh_column + 1 >= w) begin
                sh_column = 0;
                sh_row = (sh_row + 1 >= MAX_HEIGHT_DEF) ? 0 : sh_row + 1;
            end else begin
                sh_column = sh_column + 1;
            end
            if (in_win) begin
                res.pixel = intensity_of(raw);
                res.raw_value = raw;
                res.window_last = last;
                window_pixels_q.push_back(res);
            end
        end
    endfunction

    function automatic void flag_field(input string name, input int unsigned want,
                                       input int unsigned got);
        if (want != got) begin
            err_count++;
            if (err_count <= MAX_ERR_PRINTS)
                $display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h",
                         $time, name, want, got);
        end
    endfunction

    // Sample beats on every channel: update the shadow, check results in order
    always @(posedge aclk) begin : watch_beats
        pup_result_t want;
        if (aresetn) begin
            in_taken <= s_tvalid && s_tready;
            if (cfg_valid && cfg_ready) apply_reg(cfg_index, cfg_data);
            if (s_tvalid && s_tready) unpack_byte(s_tdata, s_tuser);
            if (m_tvalid && m_tready) begin
                if (window_pixels_q.size() == 0) begin
                    err_count++;
                    if (err_count <= MAX_ERR_PRINTS)
                        $display("%0t: unexpected result, expected none, actual 0x%0h last %0b",
                                 $time, m_tdata, m_tlast);
                end else begin
                    want = window_pixels_q.pop_front();
                    flag_field("pixel", want.pixel, m_tdata[7:0]);
                    flag_field("raw_value", want.raw_value, m_tdata[17:8]);
                    flag_field("window_last", want.window_last, m_tlast);
                end
            end
        end
    end

    // Sender: bursts of random length, random gaps, hold a beat until taken
    always @(negedge aclk) begin : drive_bytes
        byte_beat_t beat;
        if (!s_tvalid || in_taken) begin
            if (gap_left != 0) begin
                gap_left <= gap_left - 1;
                s_tvalid <= 1'b0;
            end else if (byte_q.size() != 0) begin
                beat = byte_q.pop_front();
                s_tvalid <= 1'b1;
                s_tdata <= beat.data;
                s_tuser <= beat.start;
                if (burst_left <= 1) begin
                    if ($urandom_range(0, 5) == 0) begin
                        burst_left <= $urandom_range(40, 120);
                        gap_left <= 0;
                    end else begin
                        burst_left <= $urandom_range(1, 12);
                        gap_left <= $urandom_range(0, 5);
                    end
                end else begin
                    burst_left <= burst_left - 1;
                end
            end else begin
                s_tvalid <= 1'b0;
            end
        end
    end

    // Receiver: segments of varying readiness, plus long hold-offs on request and periodically
    always @(negedge aclk) begin : drive_ready
        logic rdy;
        rx_cycle <= rx_cycle + 1;
        if (hold_left != 0) begin
            hold_left <= hold_left - 1;
            m_tready <= 1'b0;
        end else if (hold_done != hold_asks || rx_cycle % 3000 == 500) begin
            hold_left <= 200;
            hold_done <= hold_asks;
            m_tready <= 1'b0;
        end else begin
            if (seg_left == 0) begin
                seg_left <= $urandom_range(20, 80);
                seg_mode <= $urandom_range(0, 3);
            end else begin
                seg_left <= seg_left - 1;
            end
            case (seg_mode)
                0: rdy = 1'b1;
                1: rdy = ($urandom_range(0, 3) != 0);
                2: rdy = ($urandom_range(0, 1) != 0);
                default: rdy = ($urandom_range(0, 3) == 0);
            endcase
            m_tready <= rdy;
        end
    end

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
        @(negedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        do @(posedge aclk); while (!cfg_ready);
        @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    task automatic write_geometry(input int unsigned w, input int unsigned xb,
                                  input int unsigned ww, input int unsigned yb,
                                  input int unsigned wh);
        write_reg(CFG_IMAGE_WIDTH, CFG_DATA_W'(w));
        write_reg(CFG_WIN_X_BEGIN, CFG_DATA_W'(xb));
        write_reg(CFG_WIN_WIDTH, CFG_DATA_W'(ww));
        write_reg(CFG_WIN_Y_BEGIN, CFG_DATA_W'(yb));
        write_reg(CFG_WIN_HEIGHT, CFG_DATA_W'(wh));
    endtask

    // Wait until the stream is drained, then let the pipeline go quiet
    task automatic settle();
        while (byte_q.size() != 0 || s_tvalid || window_pixels_q.size() != 0)
            @(posedge aclk);
        repeat (8) @(posedge aclk);
    endtask

    task automatic push_byte(input logic [BYTE_W-1:0] b, input logic fs);
        byte_beat_t beat;
        beat.data = b;
        beat.start = fs;
        byte_q.push_back(beat);
    endtask

    // Pack four raw pixels MSB first into one five-byte group
    task automatic queue_group(input logic [RAW_W-1:0] r0, input logic [RAW_W-1:0] r1,
                               input logic [RAW_W-1:0] r2, input logic [RAW_W-1:0] r3,
                               input logic fs);
        push_byte(r0[9:2], fs);
        push_byte({r0[1:0], r1[9:4]}, 1'b0);
        push_byte({r1[3:0], r2[9:6]}, 1'b0);
        push_byte({r2[5:0], r3[9:8]}, 1'b0);
        push_byte(r3[7:0], 1'b0);
    endtask

    initial begin : stimulus
        int unsigned random_bytes;
        int unsigned w, xb, ww, yb, wh, rows, nbytes, frames;
        random_bytes = 0;
        repeat (2) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // Reset geometry: knees and extremes of the curve, a frame start mid-group
        queue_group(10'd342, 10'd343, 10'd683, 10'd684, 1'b1);
        queue_group(10'd0, 10'd1023, 10'h2AA, 10'h155, 1'b0);
        push_byte(8'hA5, 1'b0);
        push_byte(8'h3C, 1'b1);
        push_byte(8'hFF, 1'b0);
        push_byte(8'h00, 1'b0);
        settle();

        // Long receiver hold-off with the sender busy: queue fills, input stalls
        hold_asks++;
        for (int i = 0; i < 60; i++)
            push_byte(BYTE_W'($urandom_range(0, 255)), i == 0);
        settle();

        // Zero width means maximum; begin registers drop bit 12
        write_geometry(0, 13'h1001, 2, 0, 1);
        queue_group(10'd1, 10'd1022, 10'd341, 10'd685, 1'b1);
        settle();

        // Largest values everywhere, and writes to unused indexes
        write_geometry(13'h1FFF, 4095, 13'h1FFF, 4095, 13'h1FFF);
        write_reg(CFG_SPARE_LO, 13'h1FFF);
        write_reg(CFG_SPARE_HI, 13'h0155);
        queue_group(10'd512, 10'd0, 10'd1023, 10'd7, 1'b1);
        settle();

        // Empty window
        write_geometry(4096, 0, 0, 0, 4096);
        queue_group(10'd100, 10'd200, 10'd300, 10'd400, 1'b1);
        settle();

        // Random geometries: mostly whole frames of small images, some noise
        while (random_bytes < RANDOM_BYTES) begin
            if ($urandom_range(0, 7) == 0) w = $urandom_range(1, 23);
            else w = 4 * $urandom_range(1, 8);
            xb = $urandom_range(0, w);
            ww = $urandom_range(0, w + 1);
            yb = $urandom_range(0, 3);
            wh = $urandom_range(0, 5);
            if ($urandom_range(0, 9) == 0) begin
                case ($urandom_range(0, 3))
                    0: xb = 4095;
                    1: yb = 4095;
                    2: ww = 8191;
                    default: wh = 4096;
                endcase
            end
            write_geometry(w, xb, ww, yb, wh);
            frames = $urandom_range(1, 3);
            repeat (frames) begin
                if ($urandom_range(0, 4) != 0) begin
                    rows = yb + wh + $urandom_range(0, 1);
                    if (rows > 8) rows = 8;
                    if (rows == 0) rows = 1;
                    nbytes = 5 * ((w * rows + 3) / 4 + $urandom_range(0, 1));
                    for (int i = 0; i < nbytes; i++)
                        push_byte(BYTE_W'($urandom_range(0, 255)), i == 0);
                end else begin
                    nbytes = $urandom_range(1, 30);
                    for (int i = 0; i < nbytes; i++)
                        push_byte(BYTE_W'($urandom_range(0, 255)),
                                  $urandom_range(0, 5) == 0);
                end
                random_bytes += nbytes;
            end
            settle();
        end

        if (err_count == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

    // Hard stop well past the slowest legal run
    initial begin : watchdog
        #2000000;
        $display("TEST FAILED");
        $finish;
    end

endmodule
